[rtl/core/llx_pkg.sv]
// Package: shared types, token kind codes and character helpers for the lexer.
`timescale 1ns / 1ps
`default_nettype none
package llx_pkg;

    localparam int KEYWORD_CHARS = 6;
    localparam logic [15:0] LEN_MAX  = 16'hFFFF;
    localparam logic [23:0] LINE_MAX = 24'hFFFFFF;
    localparam logic [31:0] OFF_MAX  = 32'hFFFF_FFFF;

    // token kind codes
    localparam logic [5:0] K_LPAREN = 6'd0;
    localparam logic [5:0] K_RPAREN = 6'd1;
    localparam logic [5:0] K_LBRACE = 6'd2;
    localparam logic [5:0] K_RBRACE = 6'd3;
    localparam logic [5:0] K_COMMA  = 6'd4;
    localparam logic [5:0] K_DOT    = 6'd5;
    localparam logic [5:0] K_MINUS  = 6'd6;
    localparam logic [5:0] K_PLUS   = 6'd7;
    localparam logic [5:0] K_SEMI   = 6'd8;
    localparam logic [5:0] K_SLASH  = 6'd9;
    localparam logic [5:0] K_STAR   = 6'd10;
    localparam logic [5:0] K_BANG   = 6'd11;
    localparam logic [5:0] K_BANG_EQ = 6'd12;
    localparam logic [5:0] K_EQ     = 6'd13;
    localparam logic [5:0] K_EQ_EQ  = 6'd14;
    localparam logic [5:0] K_GT     = 6'd15;
    localparam logic [5:0] K_GT_EQ  = 6'd16;
    localparam logic [5:0] K_LT     = 6'd17;
    localparam logic [5:0] K_LT_EQ  = 6'd18;
    localparam logic [5:0] K_IDENT  = 6'd19;
    localparam logic [5:0] K_STRING = 6'd20;
    localparam logic [5:0] K_NUMBER = 6'd21;
    localparam logic [5:0] K_ERROR  = 6'd38;
    localparam logic [5:0] K_EOF    = 6'd39;

    localparam logic [1:0] E_NONE       = 2'd0;
    localparam logic [1:0] E_UNEXPECTED = 2'd1;
    localparam logic [1:0] E_UNTERM     = 2'd2;

    typedef enum logic [3:0] {
        M_IDLE, M_SLASH, M_COMMENT, M_OP, M_IDENT, M_INT, M_NUMDOT, M_FRAC, M_STRING
    } t_mode;

    // pending operator codes
    localparam logic [2:0] OP_NONE = 3'd0;
    localparam logic [2:0] OP_BANG = 3'd1;
    localparam logic [2:0] OP_EQ   = 3'd2;
    localparam logic [2:0] OP_LT   = 3'd3;
    localparam logic [2:0] OP_GT   = 3'd4;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_text;
    } t_in;

    typedef struct packed {
        logic [5:0]  kind;
        logic [1:0]  err;
        logic [31:0] off;
        logic [15:0] len;
        logic [23:0] line;
    } t_tok;

    typedef struct packed {
        logic [5:0]  token_kind;
        logic [1:0]  error_code;
        logic [31:0] token_offset;
        logic [15:0] token_length;
        logic [23:0] token_line;
        logic        last_of_run;
    } t_out;

    // all tokens caused by one byte
    typedef struct packed {
        logic [1:0]       cnt;
        t_tok [2:0]       tok;
    } t_bundle;

    typedef logic [KEYWORD_CHARS-1:0][7:0] t_prefix;

    // keyword spellings, first character in the low byte
    localparam logic [15:0][47:0] KW_WORD = '{
        48'("elihw"), 48'("rav"),   48'("eurt"),  48'("siht"),
        48'("repus"), 48'("nruter"), 48'("tnirp"), 48'("ro"),
        48'("lin"),   48'("fi"),    48'("nuf"),   48'("rof"),
        48'("eslaf"), 48'("esle"),  48'("ssalc"), 48'("dna")
    };
    localparam logic [15:0][2:0] KW_LEN = '{
        3'd5, 3'd3, 3'd4, 3'd4, 3'd5, 3'd6, 3'd5, 3'd2,
        3'd3, 3'd2, 3'd3, 3'd3, 3'd5, 3'd4, 3'd5, 3'd3
    };

    function automatic logic is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic t_tok mk_tok(logic [5:0] k, logic [1:0] e, logic [31:0] o,
                                    logic [15:0] l, logic [23:0] ln);
        t_tok t;
        t.kind = k;
        t.err  = e;
        t.off  = o;
        t.len  = l;
        t.line = ln;
        return t;
    endfunction

    // identifier or keyword kind from the stored prefix
    function automatic logic [5:0] kw_kind(t_prefix pre, logic [15:0] len);
        logic [5:0] k;
        logic       m;
        k = K_IDENT;
        for (int i = 0; i < 16; i++) begin
            m = (len == 16'(KW_LEN[i]));
            for (int j = 0; j < KEYWORD_CHARS; j++) begin
                if (j < int'(KW_LEN[i]) && pre[j] != KW_WORD[i][j*8 +: 8]) begin
                    m = 1'b0;
                end
            end
            if (m) begin
                k = 6'(22 + i);
            end
        end
        return k;
    endfunction

endpackage
`default_nettype wire

[rtl/core/lox_token_lexer.sv]
// Top level of the Lox token lexer: scanner, bundle queue and token serialiser.
//
// Input channel (i_valid/o_ready, payload i_in) takes one source byte per beat,
// or an end-of-text beat that flushes any held token and emits EOF.
// Output channel (o_valid/i_ready, payload o_out) gives one token per beat;
// last_of_run marks the final token caused by an input beat.
// Throughput: one input byte per cycle while each byte causes at most one token
// and the receiver does not stall; a byte causing several tokens sends them one
// per beat; the two-entry queue between scanner and serialiser absorbs the excess.
// A token is written to the queue when the byte that completes it is taken, and is
// shown once earlier bundles drain (a byte that only extends a token gives none).
// Reset (synchronous, active low) empties the queue and returns the scanner
// to offset 0, line 1. When the receiver stalls, the output beat holds; once
// the queue is full, o_ready drops until a bundle drains.
`timescale 1ns / 1ps
`default_nettype none
module lox_token_lexer (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_valid,
    output logic           o_ready,
    input  wire llx_pkg::t_in i_in,
    output logic           o_valid,
    input  wire            i_ready,
    output llx_pkg::t_out  o_out
);
    logic             push, pop, q_ready, q_valid;
    llx_pkg::t_bundle f_bundle, q_bundle;

    llx_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_in      (i_in),
        .i_q_ready (q_ready),
        .o_ready   (o_ready),
        .o_push    (push),
        .o_bundle  (f_bundle)
    );

    llx_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (f_bundle),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_bundle)
    );

    llx_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_bundle),
        .o_pop     (pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_out     (o_out)
    );
endmodule
`default_nettype wire

[rtl/core/llx_front.sv]
// Front end: per-byte scanner state machine, builds the bundle of tokens for each byte.
`timescale 1ns / 1ps
`default_nettype none
module llx_front (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_valid,
    input  wire llx_pkg::t_in i_in,
    input  wire             i_q_ready,
    output logic            o_ready,
    output logic            o_push,
    output llx_pkg::t_bundle o_bundle
);
    llx_pkg::t_mode   r_mode, n_mode;
    logic [2:0]       r_op, n_op;
    llx_pkg::t_prefix r_pre, n_pre;
    logic [31:0]      r_start, n_start, r_pos, n_pos;
    logic [15:0]      r_len, n_len;
    logic [23:0]      r_line, n_line;

    logic             acc;
    logic [1:0]       fl_cnt;
    llx_pkg::t_tok [1:0] fl_tok;
    logic [5:0]       op_single, op_double;
    logic [31:0]      dot_off;

    assign o_ready = i_q_ready;
    assign acc     = i_valid && i_q_ready;

    // operator kinds
    always_comb begin
        case (r_op)
            llx_pkg::OP_BANG: begin op_single = llx_pkg::K_BANG; op_double = llx_pkg::K_BANG_EQ; end
            llx_pkg::OP_EQ:   begin op_single = llx_pkg::K_EQ;   op_double = llx_pkg::K_EQ_EQ;   end
            llx_pkg::OP_LT:   begin op_single = llx_pkg::K_LT;   op_double = llx_pkg::K_LT_EQ;   end
            llx_pkg::OP_GT:   begin op_single = llx_pkg::K_GT;   op_double = llx_pkg::K_GT_EQ;   end
            default:          begin op_single = llx_pkg::K_LPAREN; op_double = llx_pkg::K_LPAREN; end
        endcase
    end

    assign dot_off = (r_pos != 32'd0) ? r_pos - 32'd1 : 32'd0;

    // held token flushed by a non-continuing byte or end of text
    always_comb begin
        fl_cnt = 2'd0;
        fl_tok = '0;
        unique case (r_mode)
            llx_pkg::M_SLASH: begin
                fl_cnt = 2'd1;
                fl_tok[0] = llx_pkg::mk_tok(llx_pkg::K_SLASH, llx_pkg::E_NONE, r_start, 16'd1,
                                            r_line);
            end
            llx_pkg::M_OP: begin
                fl_cnt = 2'd1;
                fl_tok[0] = llx_pkg::mk_tok(op_single, llx_pkg::E_NONE, r_start, 16'd1, r_line);
            end
            llx_pkg::M_IDENT: begin
                fl_cnt = 2'd1;
                fl_tok[0] = llx_pkg::mk_tok((r_len > 16'(llx_pkg::KEYWORD_CHARS)) ?
                                            llx_pkg::K_IDENT : llx_pkg::kw_kind(r_pre, r_len),
                                            llx_pkg::E_NONE, r_start, r_len, r_line);
            end
            llx_pkg::M_INT, llx_pkg::M_FRAC: begin
                fl_cnt = 2'd1;
                fl_tok[0] = llx_pkg::mk_tok(llx_pkg::K_NUMBER, llx_pkg::E_NONE, r_start, r_len,
                                            r_line);
            end
            llx_pkg::M_NUMDOT: begin
                fl_cnt = 2'd2;
                fl_tok[0] = llx_pkg::mk_tok(llx_pkg::K_NUMBER, llx_pkg::E_NONE, r_start, r_len,
                                            r_line);
                fl_tok[1] = llx_pkg::mk_tok(llx_pkg::K_DOT, llx_pkg::E_NONE, dot_off, 16'd1,
                                            r_line);
            end
            llx_pkg::M_STRING: begin
                if (i_in.end_of_text) begin
                    fl_cnt = 2'd1;
                    fl_tok[0] = llx_pkg::mk_tok(llx_pkg::K_ERROR, llx_pkg::E_UNTERM, r_start,
                                                r_len, r_line);
                end
            end
            default: ;
        endcase
    end

    // per-byte step
    always_comb begin
        logic [7:0]  b;
        logic        handled;
        logic [1:0]  cnt;
        logic [5:0]  pk;
        logic        punct;
        logic [15:0] len_inc;
        logic [23:0] line_inc;
        b        = i_in.in_byte;
        handled  = 1'b0;
        cnt      = 2'd0;
        pk       = llx_pkg::K_LPAREN;
        punct    = 1'b0;
        len_inc  = (r_len == llx_pkg::LEN_MAX) ? r_len : r_len + 16'd1;
        line_inc = (r_line == llx_pkg::LINE_MAX) ? r_line : r_line + 24'd1;
        n_mode   = r_mode;
        n_op     = r_op;
        n_pre    = r_pre;
        n_start  = r_start;
        n_len    = r_len;
        n_line   = r_line;
        n_pos    = (r_pos == llx_pkg::OFF_MAX) ? r_pos : r_pos + 32'd1;
        o_bundle = '0;

        if (i_in.end_of_text) begin
            o_bundle.tok[0] = fl_tok[0];
            o_bundle.tok[1] = fl_tok[1];
            o_bundle.tok[fl_cnt] = llx_pkg::mk_tok(llx_pkg::K_EOF, llx_pkg::E_NONE, r_pos,
                                                   16'd0, r_line);
            cnt     = fl_cnt + 2'd1;
            n_mode  = llx_pkg::M_IDLE;
            n_op    = llx_pkg::OP_NONE;
            n_start = 32'd0;
            n_len   = 16'd0;
            n_pos   = 32'd0;
            n_line  = 24'd1;
        end else begin
            unique case (r_mode)
                llx_pkg::M_SLASH: begin
                    if (b == "/") begin
                        n_mode  = llx_pkg::M_COMMENT;
                        handled = 1'b1;
                    end
                end
                llx_pkg::M_COMMENT: begin
                    if (b == 8'h0A) begin
                        n_line = line_inc;
                        n_mode = llx_pkg::M_IDLE;
                    end
                    handled = 1'b1;
                end
                llx_pkg::M_OP: begin
                    if (b == "=") begin
                        o_bundle.tok[0] = llx_pkg::mk_tok(op_double, llx_pkg::E_NONE, r_start,
                                                          16'd2, r_line);
                        cnt     = 2'd1;
                        n_mode  = llx_pkg::M_IDLE;
                        n_op    = llx_pkg::OP_NONE;
                        handled = 1'b1;
                    end
                end
                llx_pkg::M_IDENT: begin
                    if (llx_pkg::is_alpha(b) || llx_pkg::is_digit(b)) begin
                        if (r_len < 16'(llx_pkg::KEYWORD_CHARS)) begin
                            n_pre[r_len[2:0]] = b;
                        end
                        n_len   = len_inc;
                        handled = 1'b1;
                    end
                end
                llx_pkg::M_INT: begin
                    if (llx_pkg::is_digit(b)) begin
                        n_len   = len_inc;
                        handled = 1'b1;
                    end else if (b == ".") begin
                        n_mode  = llx_pkg::M_NUMDOT;
                        handled = 1'b1;
                    end
                end
                llx_pkg::M_NUMDOT: begin
                    if (llx_pkg::is_digit(b)) begin
                        n_len   = (len_inc == llx_pkg::LEN_MAX) ? len_inc : len_inc + 16'd1;
                        n_mode  = llx_pkg::M_FRAC;
                        handled = 1'b1;
                    end
                end
                llx_pkg::M_FRAC: begin
                    if (llx_pkg::is_digit(b)) begin
                        n_len   = len_inc;
                        handled = 1'b1;
                    end
                end
                llx_pkg::M_STRING: begin
                    n_len = len_inc;
                    if (b == 8'h0A) begin
                        n_line = line_inc;
                    end
                    if (b == 8'h22) begin
                        o_bundle.tok[0] = llx_pkg::mk_tok(llx_pkg::K_STRING, llx_pkg::E_NONE,
                                                          r_start, len_inc, r_line);
                        cnt    = 2'd1;
                        n_mode = llx_pkg::M_IDLE;
                    end
                    handled = 1'b1;
                end
                default: begin
                    n_mode = llx_pkg::M_IDLE;
                end
            endcase

            if (!handled) begin
                // flush the held token, then treat the byte as between tokens
                o_bundle.tok[0] = fl_tok[0];
                o_bundle.tok[1] = fl_tok[1];
                cnt    = fl_cnt;
                n_mode = llx_pkg::M_IDLE;
                n_op   = llx_pkg::OP_NONE;
                case (b)
                    8'h20, 8'h09, 8'h0D: ;
                    8'h0A: n_line = line_inc;
                    "(": begin punct = 1'b1; pk = llx_pkg::K_LPAREN; end
                    ")": begin punct = 1'b1; pk = llx_pkg::K_RPAREN; end
                    "{": begin punct = 1'b1; pk = llx_pkg::K_LBRACE; end
                    "}": begin punct = 1'b1; pk = llx_pkg::K_RBRACE; end
                    ",": begin punct = 1'b1; pk = llx_pkg::K_COMMA;  end
                    ".": begin punct = 1'b1; pk = llx_pkg::K_DOT;    end
                    "-": begin punct = 1'b1; pk = llx_pkg::K_MINUS;  end
                    "+": begin punct = 1'b1; pk = llx_pkg::K_PLUS;   end
                    ";": begin punct = 1'b1; pk = llx_pkg::K_SEMI;   end
                    "*": begin punct = 1'b1; pk = llx_pkg::K_STAR;   end
                    "/": begin n_mode = llx_pkg::M_SLASH; n_start = r_pos; n_len = 16'd1; end
                    8'h22: begin
                        n_mode = llx_pkg::M_STRING; n_start = r_pos; n_len = 16'd1;
                    end
                    "!", "=", "<", ">": begin
                        n_mode  = llx_pkg::M_OP;
                        n_start = r_pos;
                        n_len   = 16'd1;
                        n_op    = (b == "!") ? llx_pkg::OP_BANG :
                                  (b == "=") ? llx_pkg::OP_EQ :
                                  (b == "<") ? llx_pkg::OP_LT : llx_pkg::OP_GT;
                    end
                    default: begin
                        if (llx_pkg::is_alpha(b)) begin
                            n_mode   = llx_pkg::M_IDENT;
                            n_start  = r_pos;
                            n_len    = 16'd1;
                            n_pre[0] = b;
                        end else if (llx_pkg::is_digit(b)) begin
                            n_mode  = llx_pkg::M_INT;
                            n_start = r_pos;
                            n_len   = 16'd1;
                        end else begin
                            punct = 1'b1;
                            pk    = llx_pkg::K_ERROR;
                        end
                    end
                endcase
                if (punct) begin
                    o_bundle.tok[fl_cnt] = llx_pkg::mk_tok(pk,
                        (pk == llx_pkg::K_ERROR) ? llx_pkg::E_UNEXPECTED : llx_pkg::E_NONE,
                        r_pos, 16'd1, n_line);
                    cnt = fl_cnt + 2'd1;
                end
            end
        end
        o_bundle.cnt = cnt;
        o_push       = acc && (cnt != 2'd0);
    end

    // scanner state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= llx_pkg::M_IDLE;
            r_op    <= llx_pkg::OP_NONE;
            r_start <= 32'd0;
            r_len   <= 16'd0;
            r_pos   <= 32'd0;
            r_line  <= 24'd1;
        end else if (acc) begin
            r_mode  <= n_mode;
            r_op    <= n_op;
            r_start <= n_start;
            r_len   <= n_len;
            r_pos   <= n_pos;
            r_line  <= n_line;
        end
    end

    // identifier prefix, no reset
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_pre <= n_pre;
        end
    end
endmodule
`default_nettype wire

[rtl/core/llx_queue.sv]
// Two-entry bundle queue between the scanner and the token serialiser.
`timescale 1ns / 1ps
`default_nettype none
module llx_queue (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  wire llx_pkg::t_bundle i_data,
    output logic             o_ready,
    input  wire              i_pop,
    output logic             o_valid,
    output llx_pkg::t_bundle o_data
);
    llx_pkg::t_bundle [1:0] r_mem;
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end
endmodule
`default_nettype wire

[rtl/core/llx_back.sv]
// Back end: sends the tokens of each bundle one beat at a time.
`timescale 1ns / 1ps
`default_nettype none
module llx_back (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_q_valid,
    input  wire llx_pkg::t_bundle i_q_data,
    output logic             o_pop,
    output logic             o_valid,
    input  wire              i_ready,
    output llx_pkg::t_out    o_out
);
    logic [1:0]    r_idx;
    logic          last;
    llx_pkg::t_tok t;

    assign t       = i_q_data.tok[r_idx];
    assign last    = (r_idx == i_q_data.cnt - 2'd1);
    assign o_valid = i_q_valid;
    assign o_pop   = i_q_valid && i_ready && last;

    always_comb begin
        o_out.token_kind   = t.kind;
        o_out.error_code   = t.err;
        o_out.token_offset = t.off;
        o_out.token_length = t.len;
        o_out.token_line   = t.line;
        o_out.last_of_run  = last;
    end

    // token index within the bundle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 2'd0;
        end else if (i_q_valid && i_ready) begin
            r_idx <= last ? 2'd0 : r_idx + 2'd1;
        end
    end
endmodule
`default_nettype wire

[tb/sv/tb_lox_token_lexer.sv]
// Testbench for the Lox token lexer: byte stimulus, token prediction and checking.
`timescale 1ns / 1ps
`default_nettype none
module tb_lox_token_lexer;

    localparam int WATCHDOG_LIMIT = 4000;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_valid;
    logic          o_ready;
    llx_pkg::t_in  i_in;
    logic          o_valid;
    logic          i_ready;
    llx_pkg::t_out o_out;

    lox_token_lexer i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_in    (i_in),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_out   (o_out)
    );

    // predictor state
    llx_pkg::t_mode sc_mode;
    logic [2:0]  sc_op;
    logic [7:0]  sc_prefix [llx_pkg::KEYWORD_CHARS];
    logic [31:0] sc_start;
    logic [15:0] sc_len;
    logic [31:0] sc_pos;
    logic [23:0] sc_line;

    llx_pkg::t_in  byte_queue [$];
    llx_pkg::t_out token_queue [$];
    llx_pkg::t_out step_toks [$];
    int   fail_count = 0;
    bit   stim_done = 0;
    bit   calm = 0;
    int   hold_long = 0;
    bit   hold_used = 0;
    int   send_gap = 0;
    int   recv_gap = 0;
    int   quiet_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic is_dig(logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_let(logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
    endfunction

    function automatic logic [15:0] len_inc(logic [15:0] v);
        return v == llx_pkg::LEN_MAX ? v : v + 16'd1;
    endfunction

    function automatic logic [23:0] line_inc(logic [23:0] v);
        return v == llx_pkg::LINE_MAX ? v : v + 24'd1;
    endfunction

    task automatic emit(logic [5:0] k, logic [1:0] e, logic [31:0] o, logic [15:0] l);
        llx_pkg::t_out t;
        t.token_kind   = k;
        t.error_code   = e;
        t.token_offset = o;
        t.token_length = l;
        t.token_line   = sc_line;
        t.last_of_run  = 1'b0;
        if (step_toks.size() < 3) step_toks.push_back(t);
    endtask

    // identifier or keyword, matched by spelling
    function automatic logic [5:0] word_kind();
        string w;
        string words [16];
        w = "";
        words = '{"and", "class", "else", "false", "for", "fun", "if", "nil", "or",
                  "print", "return", "super", "this", "true", "var", "while"};
        if (sc_len > llx_pkg::KEYWORD_CHARS) return llx_pkg::K_IDENT;
        for (int i = 0; i < sc_len; i++) w = {w, string'(sc_prefix[i])};
        for (int i = 0; i < 16; i++)
            if (w == words[i]) return 6'(22 + i);
        return llx_pkg::K_IDENT;
    endfunction

    function automatic logic [5:0] op_kind(logic [2:0] op, bit dbl);
        case (op)
            llx_pkg::OP_BANG: return dbl ? llx_pkg::K_BANG_EQ : llx_pkg::K_BANG;
            llx_pkg::OP_EQ:   return dbl ? llx_pkg::K_EQ_EQ : llx_pkg::K_EQ;
            llx_pkg::OP_LT:   return dbl ? llx_pkg::K_LT_EQ : llx_pkg::K_LT;
            llx_pkg::OP_GT:   return dbl ? llx_pkg::K_GT_EQ : llx_pkg::K_GT;
            default: return llx_pkg::K_LPAREN;
        endcase
    endfunction

    task automatic flush_held(bit at_end);
        case (sc_mode)
            llx_pkg::M_SLASH: emit(llx_pkg::K_SLASH, llx_pkg::E_NONE, sc_start, 16'd1);
            llx_pkg::M_OP:    emit(op_kind(sc_op, 0), llx_pkg::E_NONE, sc_start, 16'd1);
            llx_pkg::M_IDENT: emit(word_kind(), llx_pkg::E_NONE, sc_start, sc_len);
            llx_pkg::M_INT, llx_pkg::M_FRAC:
                emit(llx_pkg::K_NUMBER, llx_pkg::E_NONE, sc_start, sc_len);
            llx_pkg::M_NUMDOT: begin
                emit(llx_pkg::K_NUMBER, llx_pkg::E_NONE, sc_start, sc_len);
                emit(llx_pkg::K_DOT, llx_pkg::E_NONE, sc_pos == 0 ? 32'd0 : sc_pos - 32'd1,
                     16'd1);
            end
            llx_pkg::M_STRING:
                if (at_end) emit(llx_pkg::K_ERROR, llx_pkg::E_UNTERM, sc_start, sc_len);
            default: ;
        endcase
        sc_mode = llx_pkg::M_IDLE;
        sc_op   = llx_pkg::OP_NONE;
    endtask

    task automatic begin_tok(llx_pkg::t_mode m, logic [31:0] p);
        sc_mode  = m;
        sc_start = p;
        sc_len   = 16'd1;
    endtask

    task automatic scan_fresh(logic [7:0] b, logic [31:0] p);
        case (b)
            8'h20, 8'h09, 8'h0d: ;
            8'h0a: sc_line = line_inc(sc_line);
            "(": emit(llx_pkg::K_LPAREN, llx_pkg::E_NONE, p, 16'd1);
            ")": emit(llx_pkg::K_RPAREN, llx_pkg::E_NONE, p, 16'd1);
            "{": emit(llx_pkg::K_LBRACE, llx_pkg::E_NONE, p, 16'd1);
            "}": emit(llx_pkg::K_RBRACE, llx_pkg::E_NONE, p, 16'd1);
            ",": emit(llx_pkg::K_COMMA, llx_pkg::E_NONE, p, 16'd1);
            ".": emit(llx_pkg::K_DOT, llx_pkg::E_NONE, p, 16'd1);
            "-": emit(llx_pkg::K_MINUS, llx_pkg::E_NONE, p, 16'd1);
            "+": emit(llx_pkg::K_PLUS, llx_pkg::E_NONE, p, 16'd1);
            ";": emit(llx_pkg::K_SEMI, llx_pkg::E_NONE, p, 16'd1);
            "*": emit(llx_pkg::K_STAR, llx_pkg::E_NONE, p, 16'd1);
            "/": begin_tok(llx_pkg::M_SLASH, p);
            8'h22: begin_tok(llx_pkg::M_STRING, p);
            "!": begin begin_tok(llx_pkg::M_OP, p); sc_op = llx_pkg::OP_BANG; end
            "=": begin begin_tok(llx_pkg::M_OP, p); sc_op = llx_pkg::OP_EQ; end
            "<": begin begin_tok(llx_pkg::M_OP, p); sc_op = llx_pkg::OP_LT; end
            ">": begin begin_tok(llx_pkg::M_OP, p); sc_op = llx_pkg::OP_GT; end
            default: begin
                if (is_let(b)) begin
                    begin_tok(llx_pkg::M_IDENT, p);
                    sc_prefix[0] = b;
                end else if (is_dig(b)) begin
                    begin_tok(llx_pkg::M_INT, p);
                end else begin
                    emit(llx_pkg::K_ERROR, llx_pkg::E_UNEXPECTED, p, 16'd1);
                end
            end
        endcase
    endtask

    task automatic lexer_reset();
        sc_mode  = llx_pkg::M_IDLE;
        sc_op    = llx_pkg::OP_NONE;
        sc_start = '0;
        sc_len   = '0;
        sc_pos   = '0;
        sc_line  = 24'd1;
        for (int i = 0; i < llx_pkg::KEYWORD_CHARS; i++) sc_prefix[i] = '0;
    endtask

    // predict the tokens of one accepted beat
    task automatic predict_tokens(llx_pkg::t_in it);
        logic [31:0] p;
        bit          done;
        p = sc_pos;
        done = 0;
        step_toks.delete();
        if (it.end_of_text) begin
            flush_held(1);
            emit(llx_pkg::K_EOF, llx_pkg::E_NONE, sc_pos, 16'd0);
            lexer_reset();
        end else begin
            case (sc_mode)
                llx_pkg::M_SLASH: if (it.in_byte == "/") begin
                    sc_mode = llx_pkg::M_COMMENT;
                    done = 1;
                end
                llx_pkg::M_COMMENT: begin
                    if (it.in_byte == 8'h0a) begin
                        sc_line = line_inc(sc_line);
                        sc_mode = llx_pkg::M_IDLE;
                    end
                    done = 1;
                end
                llx_pkg::M_OP: if (it.in_byte == "=") begin
                    emit(op_kind(sc_op, 1), llx_pkg::E_NONE, sc_start, 16'd2);
                    sc_mode = llx_pkg::M_IDLE;
                    sc_op = llx_pkg::OP_NONE;
                    done = 1;
                end
                llx_pkg::M_IDENT: if (is_let(it.in_byte) || is_dig(it.in_byte)) begin
                    if (sc_len < llx_pkg::KEYWORD_CHARS) sc_prefix[sc_len] = it.in_byte;
                    sc_len = len_inc(sc_len);
                    done = 1;
                end
                llx_pkg::M_INT: begin
                    if (is_dig(it.in_byte)) begin
                        sc_len = len_inc(sc_len);
                        done = 1;
                    end else if (it.in_byte == ".") begin
                        sc_mode = llx_pkg::M_NUMDOT;
                        done = 1;
                    end
                end
                llx_pkg::M_NUMDOT: if (is_dig(it.in_byte)) begin
                    sc_len = len_inc(len_inc(sc_len));
                    sc_mode = llx_pkg::M_FRAC;
                    done = 1;
                end
                llx_pkg::M_FRAC: if (is_dig(it.in_byte)) begin
                    sc_len = len_inc(sc_len);
                    done = 1;
                end
                llx_pkg::M_STRING: begin
                    sc_len = len_inc(sc_len);
                    if (it.in_byte == 8'h0a) sc_line = line_inc(sc_line);
                    if (it.in_byte == 8'h22) begin
                        emit(llx_pkg::K_STRING, llx_pkg::E_NONE, sc_start, sc_len);
                        sc_mode = llx_pkg::M_IDLE;
                    end
                    done = 1;
                end
                default: sc_mode = llx_pkg::M_IDLE;
            endcase
            if (!done) begin
                flush_held(0);
                scan_fresh(it.in_byte, p);
            end
            sc_pos = (p == llx_pkg::OFF_MAX) ? p : p + 32'd1;
        end
        if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last_of_run = 1'b1;
        foreach (step_toks[i]) token_queue.push_back(step_toks[i]);
    endtask

    // stimulus helpers
    function automatic void add_byte(logic [7:0] b);
        llx_pkg::t_in t;
        t.in_byte = b;
        t.end_of_text = 1'b0;
        byte_queue.push_back(t);
    endfunction

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    endfunction

    function automatic void add_end(logic [7:0] junk);
        llx_pkg::t_in t;
        t.in_byte = junk;
        t.end_of_text = 1'b1;
        byte_queue.push_back(t);
    endfunction

    function automatic string rand_piece();
        string pieces [26];
        string s;
        pieces = '{"and", "class", "else", "false", "for", "fun", "if", "nil", "or",
                   "print", "return", "super", "this", "true", "var", "while",
                   "x_9", "classy", "==", "!=", "<=", ">=", "12.5", "7.", "//c\n", "\"s\n\""};
        case ($urandom_range(0, 9))
            0, 1, 2, 3: s = pieces[$urandom_range(0, 25)];
            4: s = string'(8'($urandom_range(0, 255)));
            5: s = " ";
            6: s = "\n";
            7: s = string'(8'($urandom_range(33, 126)));
            8: s = $sformatf("%0d", $urandom_range(0, 999));
            default: s = "(";
        endcase
        return s;
    endfunction

    initial begin
        int n;
        string s;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_in    = '0;
        i_ready = 1'b0;
        lexer_reset();
        // directed: operators, keywords, specials
        add_text("(){},.-+;*! != = == > >= < <= /x");
        add_byte(8'h00);
        add_byte(8'hFF);
        add_text("and class else false for fun if nil or print return super");
        add_text(" this true var while whiles ab_1 12.34 5. 7.x // note\n\"a\nb\" ");
        add_end(8'hAA);
        add_text("9.");
        add_end(8'h55);
        add_text("\"open");
        add_end(8'h00);
        add_text("/");
        add_end(8'hFF);
        n = 0;
        while (n < 205) begin
            if ($urandom_range(0, 30) == 0) begin
                add_end(8'($urandom()));
                n++;
            end else begin
                s = rand_piece();
                add_text(s);
                n += s.len();
            end
        end
        add_end(8'h00);
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                predict_tokens(i_in);
                void'(byte_queue.pop_front());
            end
            if (i_valid && !o_ready) begin
                // hold the beat
            end else if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                i_valid <= 1'b0;
            end else if (byte_queue.size() > (i_valid && o_ready ? 0 : 0)) begin
                if (!calm && $urandom_range(0, 7) == 0) begin
                    send_gap <= $urandom_range(0, 3);
                    i_valid <= 1'b0;
                end else begin
                    i_in <= byte_queue[0];
                    i_valid <= 1'b1;
                end
            end else begin
                i_valid <= 1'b0;
                stim_done <= 1'b1;
            end
        end
    end

    // receiver with random stalls and one long hold-off
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            calm <= (byte_queue.size() < 60);
            if (!hold_used && byte_queue.size() < 250) begin
                hold_used <= 1'b1;
                hold_long <= 40;
                i_ready <= 1'b0;
            end else if (hold_long > 0) begin
                hold_long <= hold_long - 1;
                i_ready <= (hold_long == 1);
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                i_ready <= (recv_gap == 1);
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                recv_gap <= $urandom_range(1, 4);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // monitor and checker
    always @(posedge i_clk) begin
        llx_pkg::t_out want;
        if (i_rst_n && o_valid && i_ready) begin
            if (token_queue.size() == 0) begin
                $error("token with nothing expected: kind %0d", o_out.token_kind);
                fail_count++;
            end else begin
                want = token_queue.pop_front();
                if (o_out.token_kind !== want.token_kind) begin
                    $error("token_kind: expected %0d, got %0d",
                           want.token_kind, o_out.token_kind);
                    fail_count++;
                end
                if (o_out.error_code !== want.error_code) begin
                    $error("error_code: expected %0d, got %0d",
                           want.error_code, o_out.error_code);
                    fail_count++;
                end
                if (o_out.token_offset !== want.token_offset) begin
                    $error("token_offset: expected %0d, got %0d",
                           want.token_offset, o_out.token_offset);
                    fail_count++;
                end
                if (o_out.token_length !== want.token_length) begin
                    $error("token_length: expected %0d, got %0d",
                           want.token_length, o_out.token_length);
                    fail_count++;
                end
                if (o_out.token_line !== want.token_line) begin
                    $error("token_line: expected %0d, got %0d",
                           want.token_line, o_out.token_line);
                    fail_count++;
                end
                if (o_out.last_of_run !== want.last_of_run) begin
                    $error("last_of_run: expected %0d, got %0d",
                           want.last_of_run, o_out.last_of_run);
                    fail_count++;
                end
            end
        end
    end

    // watchdog and end of run
    initial begin
        int drain;
        drain = 0;
        @(posedge i_rst_n);
        while (!(stim_done && token_queue.size() == 0 && drain >= 10)) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (stim_done && token_queue.size() == 0) drain++;
            else drain = 0;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
`default_nettype wire

[filelist.f]
rtl/core/llx_pkg.sv
rtl/core/llx_front.sv
rtl/core/llx_queue.sv
rtl/core/llx_back.sv
rtl/core/lox_token_lexer.sv
tb/sv/tb_lox_token_lexer.sv
